FILE: sv/audio_level_meter_tracker_defines.svh
// Assertion macros for the level meter tracker checker.
// Depends on clk and rst being visible where a macro is used.
`ifndef AUDIO_LEVEL_METER_TRACKER_DEFINES_SVH
`define AUDIO_LEVEL_METER_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define ALM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ALM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/alm_pkg.sv
// Shared types and constants for the level meter tracker.
// No dependencies; compiled first.
package alm_pkg;

  localparam int COEF_W     = 16;
  localparam int HOLD_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int TEMPO_W    = 13;
  localparam int TIME_W     = 16;
  localparam int TIMER_W    = 20;

  localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd9830;
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 20'd500000;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 13'd1920;
  localparam logic [TEMPO_W-1:0] TEMPO_LOW   = 13'd480;
  localparam logic [TEMPO_W-1:0] TEMPO_HIGH  = 13'd4800;

  // Q0.16 decay factors: 0.9, 0.85, 0.95
  localparam logic [COEF_W-1:0] K_HIT   = 16'd58982;
  localparam logic [COEF_W-1:0] K_PULSE = 16'd55706;
  localparam logic [COEF_W-1:0] K_PEAK  = 16'd62259;

  typedef enum logic [0:0] {
    REG_COEF = 1'b0,
    REG_HOLD = 1'b1
  } cfg_reg_t;

  // Command to the serial multiplier
  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] coef;
  } smul_cmd_t;

endpackage

FILE: sv/alm_in_if.sv
// Input channel of the level meter tracker: one analysis frame per word.
// Depends on alm_pkg.
interface alm_in_if #(parameter int LEVEL_BITS = 16) ();
  import alm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [LEVEL_BITS-1:0]   energy_in;
  logic [LEVEL_BITS-1:0]   bass_in;
  logic [LEVEL_BITS-1:0]   mid_in;
  logic [LEVEL_BITS-1:0]   treble_in;
  logic [LEVEL_BITS-1:0]   phase_in;
  logic [LEVEL_BITS-1:0]   hit_in;
  logic [TEMPO_W-1:0]      tempo_in;
  logic [TIME_W-1:0]       frame_time_us;

  modport source (output valid, energy_in, bass_in, mid_in, treble_in, phase_in, hit_in,
                  tempo_in, frame_time_us, input ready);
  modport sink (input valid, energy_in, bass_in, mid_in, treble_in, phase_in, hit_in,
                tempo_in, frame_time_us, output ready);
endinterface

FILE: sv/alm_out_if.sv
// Output channel of the level meter tracker: one set of levels per word.
// Depends on alm_pkg.
interface alm_out_if #(parameter int LEVEL_BITS = 16) ();
  import alm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [LEVEL_BITS-1:0]   energy_level;
  logic [LEVEL_BITS-1:0]   bass_level;
  logic [LEVEL_BITS-1:0]   mid_level;
  logic [LEVEL_BITS-1:0]   treble_level;
  logic [TEMPO_W-1:0]      tempo_level;
  logic [LEVEL_BITS-1:0]   hit_level;
  logic [LEVEL_BITS-1:0]   pulse_level;
  logic [1:0]              rim_style;
  logic [LEVEL_BITS-1:0]   meter_level;
  logic [LEVEL_BITS-1:0]   peak_level;
  logic [2:0]              anim_frame;

  modport source (output valid, energy_level, bass_level, mid_level, treble_level,
                  tempo_level, hit_level, pulse_level, rim_style, meter_level,
                  peak_level, anim_frame, input ready);
  modport sink (input valid, energy_level, bass_level, mid_level, treble_level,
                tempo_level, hit_level, pulse_level, rim_style, meter_level,
                peak_level, anim_frame, output ready);
endinterface

FILE: sv/alm_smul.sv
// Bit-serial multiplier: prod = floor(a * coef / 2^16), one coefficient bit per cycle.
// Depends on alm_pkg.
module alm_smul #(
  parameter int AW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  alm_pkg::smul_cmd_t cmd,
  input  logic [AW-1:0]      a,
  output logic [AW-1:0]      prod,
  output logic               done
);
  import alm_pkg::*;

  localparam int CW    = COEF_W;
  localparam int CNT_W = $clog2(CW);

  logic [AW-1:0]    a_reg;
  logic [AW-1:0]    hi;
  logic [CW-1:0]    bsh;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [AW:0]      sum;

  // Add the multiplicand when the current coefficient bit is set
  assign sum  = {1'b0, hi} + (bsh[0] ? {1'b0, a_reg} : '0);
  assign prod = hi;

  // Shift-add loop; low product bits fall off the right end
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        a_reg <= a;
        hi    <= '0;
        bsh   <= cmd.coef;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        hi  <= sum[AW:1];
        bsh <= bsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/audio_level_meter_tracker.sv
// Level meter tracker top level: smoothers, hit/pulse decay, peak hold meter.
// Depends on alm_pkg, alm_in_if, alm_out_if and alm_smul.
//
//   channel    dir   handshake        word
//   in_ch      in    valid / ready    one analysis frame
//   out_ch     out   valid / ready    smoothed levels, rim style, animation frame
//   cfg        in    cfg_we           register write (index, data)
//
// A frame runs from accept to the next accept in this order: it is taken, a
// serial divide forms the tempo coefficient, 9 products go through the one
// shared bit-serial multiplier, and the output register is loaded.
// rst is synchronous; it restores register defaults, clears the levels and
// sets the tempo level to 120 bpm.
// A frame is taken while a finished word still waits on out_ch; the next
// word is held back until out_ch takes the earlier one.
module audio_level_meter_tracker #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  alm_pkg::cfg_reg_t                 cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]    cfg_data,
  alm_in_if.sink                            in_ch,
  alm_out_if.source                         out_ch
);
  import alm_pkg::*;

  localparam int W         = LEVEL_BITS;
  localparam int MW        = (W > TEMPO_W) ? W : TEMPO_W;
  localparam int DIV_STEPS = COEF_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int TS_W      = TIMER_W + 1;
  localparam longint SCALE  = longint'(1) << W;
  // Smallest pulse reaching each rim style
  localparam longint STY_T1 = (10 * SCALE + 38) / 39;
  localparam longint STY_T2 = (20 * SCALE + 38) / 39;
  localparam longint STY_T3 = (30 * SCALE + 38) / 39;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOAD, S_WAIT, S_DONE} state_t;
  typedef enum logic [3:0] {
    OP_ENERGY, OP_BASS, OP_MID, OP_TREBLE, OP_TEMPO,
    OP_HIT, OP_PULSE, OP_METER, OP_PEAK
  } op_t;

  state_t state;
  op_t    op;

  logic [COEF_W-1:0]  coef_reg;
  logic [HOLD_W-1:0]  hold_limit;

  logic [W-1:0]       energy_acc, bass_acc, mid_acc, treble_acc;
  logic [TEMPO_W-1:0] tempo_acc;
  logic [W-1:0]       hit_acc, pulse_acc, meter_acc, peak_acc;
  logic [TIMER_W-1:0] hold_timer;

  logic [W-1:0]       x_energy, x_bass, x_mid, x_treble;
  logic [TEMPO_W-1:0] x_tempo;
  logic [2:0]         anim_frame_reg;
  logic               new_hit, peak_decay, tempo_ok;

  logic [DIV_STEPS-1:0] dsh;
  logic [3:0]           rem;
  logic [COEF_W-1:0]    k_tempo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [4:0]           rem5;
  logic                 rem_ge;
  logic [DIV_STEPS-1:0] k3;

  logic [COEF_W:0]    km_sum;
  logic [COEF_W-1:0]  k_meter;
  logic [TS_W-1:0]    t_sum;
  logic [TIMER_W-1:0] t_sat;

  logic [MW-1:0]      op_cur, op_tgt, op_diff, op_new, mul_a, mul_prod;
  logic [COEF_W-1:0]  op_coef;
  logic               op_glide, op_up, up;
  logic               mul_done;
  smul_cmd_t          mul_cmd;
  logic [1:0]         style;

  // Coefficients for tempo and meter
  assign k3      = {2'b00, coef_reg} + {1'b0, coef_reg, 1'b0};
  assign km_sum  = {1'b0, coef_reg} + {2'b00, coef_reg[COEF_W-1:1]};
  assign k_meter = km_sum[COEF_W] ? '1 : km_sum[COEF_W-1:0];

  // Restoring divide by ten, one quotient bit per cycle
  assign rem5   = {rem, dsh[DIV_STEPS-1]};
  assign rem_ge = (rem5 >= 5'd10);

  // Hold timer advance with saturation
  assign t_sum = {1'b0, hold_timer} + TS_W'(in_ch.frame_time_us);
  assign t_sat = t_sum[TIMER_W] ? '1 : t_sum[TIMER_W-1:0];

  // Select operands of the current product
  always_comb begin
    op_cur   = '0;
    op_tgt   = '0;
    op_coef  = '0;
    op_glide = 1'b0;
    unique case (op)
      OP_ENERGY: begin
        op_cur = MW'(energy_acc); op_tgt = MW'(x_energy); op_coef = coef_reg; op_glide = 1'b1;
      end
      OP_BASS: begin
        op_cur = MW'(bass_acc); op_tgt = MW'(x_bass); op_coef = coef_reg; op_glide = 1'b1;
      end
      OP_MID: begin
        op_cur = MW'(mid_acc); op_tgt = MW'(x_mid); op_coef = coef_reg; op_glide = 1'b1;
      end
      OP_TREBLE: begin
        op_cur = MW'(treble_acc); op_tgt = MW'(x_treble); op_coef = coef_reg; op_glide = 1'b1;
      end
      OP_TEMPO: begin
        op_cur = MW'(tempo_acc); op_tgt = MW'(x_tempo); op_coef = k_tempo; op_glide = 1'b1;
      end
      OP_HIT: begin
        op_cur = MW'(hit_acc); op_coef = K_HIT;
      end
      OP_PULSE: begin
        op_cur = MW'(pulse_acc); op_coef = K_PULSE;
      end
      OP_METER: begin
        op_cur = MW'(meter_acc); op_tgt = MW'(x_energy); op_coef = k_meter; op_glide = 1'b1;
      end
      OP_PEAK: begin
        op_cur = MW'(peak_acc); op_coef = K_PEAK;
      end
      default: begin
        op_cur = '0;
      end
    endcase
  end

  // Glide moves toward the target by the truncated product; decay takes it as is
  assign op_up   = (op_tgt >= op_cur);
  assign op_diff = op_up ? (op_tgt - op_cur) : (op_cur - op_tgt);
  assign mul_a   = op_glide ? op_diff : op_cur;
  assign op_new  = !op_glide ? mul_prod : (up ? (op_cur + mul_prod) : (op_cur - mul_prod));

  assign mul_cmd.start = (state == S_LOAD);
  assign mul_cmd.coef  = op_coef;

  alm_smul #(.AW(MW)) u_smul (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mul_cmd),
    .a    (mul_a),
    .prod (mul_prod),
    .done (mul_done)
  );

  // Rim style from the final pulse
  always_comb begin
    priority if (pulse_acc >= STY_T3[W-1:0]) style = 2'd3;
    else if (pulse_acc >= STY_T2[W-1:0]) style = 2'd2;
    else if (pulse_acc >= STY_T1[W-1:0]) style = 2'd1;
    else style = 2'd0;
  end

  assign in_ch.ready = (state == S_IDLE);

  // Sequencer, levels and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_ENERGY;
      coef_reg     <= COEF_RESET;
      hold_limit   <= HOLD_RESET;
      energy_acc   <= '0;
      bass_acc     <= '0;
      mid_acc      <= '0;
      treble_acc   <= '0;
      tempo_acc    <= TEMPO_RESET;
      hit_acc      <= '0;
      pulse_acc    <= '0;
      meter_acc    <= '0;
      peak_acc     <= '0;
      hold_timer   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF: coef_reg   <= cfg_data[COEF_W-1:0];
          REG_HOLD: hold_limit <= cfg_data[HOLD_W-1:0];
          default:  coef_reg   <= coef_reg;
        endcase
      end

      // Drop the output word once taken, unless a new one loads now
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_energy       <= in_ch.energy_in;
            x_bass         <= in_ch.bass_in;
            x_mid          <= in_ch.mid_in;
            x_treble       <= in_ch.treble_in;
            x_tempo        <= in_ch.tempo_in;
            anim_frame_reg <= in_ch.phase_in[W-1 -: 3];
            tempo_ok       <= (in_ch.tempo_in > TEMPO_LOW) && (in_ch.tempo_in < TEMPO_HIGH);
            // Stronger hit: jump both hit and pulse
            if (in_ch.hit_in > hit_acc) begin
              new_hit   <= 1'b1;
              hit_acc   <= in_ch.hit_in;
              pulse_acc <= in_ch.hit_in;
            end else begin
              new_hit <= 1'b0;
            end
            // New maximum: take the peak and restart the hold timer
            if (in_ch.energy_in > peak_acc) begin
              peak_acc   <= in_ch.energy_in;
              hold_timer <= '0;
              peak_decay <= 1'b0;
            end else begin
              hold_timer <= t_sat;
              peak_decay <= (t_sat > hold_limit);
            end
            dsh     <= k3;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_ge ? 4'(rem5 - 5'd10) : rem5[3:0];
          k_tempo <= {k_tempo[COEF_W-2:0], rem_ge};
          dsh     <= {dsh[DIV_STEPS-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            op    <= OP_ENERGY;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          up    <= op_up;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            unique case (op)
              OP_ENERGY: energy_acc <= op_new[W-1:0];
              OP_BASS:   bass_acc   <= op_new[W-1:0];
              OP_MID:    mid_acc    <= op_new[W-1:0];
              OP_TREBLE: treble_acc <= op_new[W-1:0];
              OP_TEMPO:  if (tempo_ok) tempo_acc <= op_new[TEMPO_W-1:0];
              OP_HIT:    if (!new_hit) hit_acc <= op_new[W-1:0];
              OP_PULSE:  if (!new_hit) pulse_acc <= op_new[W-1:0];
              OP_METER:  meter_acc <= op_new[W-1:0];
              OP_PEAK:   if (peak_decay) peak_acc <= op_new[W-1:0];
              default:   meter_acc <= meter_acc;
            endcase
            if (op == OP_PEAK) begin
              state <= S_DONE;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          // Load the word once the output register is free
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.energy_level <= energy_acc;
            out_ch.bass_level   <= bass_acc;
            out_ch.mid_level    <= mid_acc;
            out_ch.treble_level <= treble_acc;
            out_ch.tempo_level  <= tempo_acc;
            out_ch.hit_level    <= hit_acc;
            out_ch.pulse_level  <= pulse_acc;
            out_ch.rim_style    <= style;
            out_ch.meter_level  <= meter_acc;
            out_ch.peak_level   <= peak_acc;
            out_ch.anim_frame   <= anim_frame_reg;
            out_ch.valid        <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/alm_check.sv
// Port-level checker for the level meter tracker, bound to the top level.
// Depends on audio_level_meter_tracker_defines.svh and the top level.
`include "audio_level_meter_tracker_defines.svh"

module alm_check #(
  parameter int LEVEL_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] energy_level,
  input logic [LEVEL_BITS-1:0] hit_level,
  input logic [LEVEL_BITS-1:0] pulse_level
);

  logic [3*LEVEL_BITS-1:0] word_bits;

  // Watched slice of the output word
  assign word_bits = {energy_level, hit_level, pulse_level};

  // Hold a stalled word
  `ALM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")
  `ALM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(word_bits), "word changed")

  // Busy once a frame is taken
  `ALM_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "frame taken while busy")
  `ALM_ASSERT_NEXT(a_no_early, in_valid && in_ready && !out_valid, !out_valid, "result too early")

  // Pulse decays at least as fast as the hit level
  `ALM_ASSERT_NOW(a_pulse_le_hit, out_valid, pulse_level <= hit_level, "pulse above hit level")

endmodule

bind audio_level_meter_tracker alm_check #(.LEVEL_BITS(LEVEL_BITS)) u_alm_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .energy_level (out_ch.energy_level),
  .hit_level    (out_ch.hit_level),
  .pulse_level  (out_ch.pulse_level)
);
